@@ hdl/u8lc_pkg.sv @@
// u8lc_pkg: shared types and constants of the utf-8 line and column tracker
// used by the channel interfaces, the update step and the top level
`timescale 1ns / 1ps
`default_nettype none
package u8lc_pkg;

  localparam int unsigned COUNT_W = 24;
  localparam int unsigned CP_W    = 21;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 24'd1;

  localparam logic [CP_W-1:0] CP_LF = 21'h00000A;
  localparam logic [CP_W-1:0] CP_CR = 21'h00000D;
  localparam logic [CP_W-1:0] CP_LS = 21'h002028;
  localparam logic [CP_W-1:0] CP_PS = 21'h002029;

  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] LEAD2_FIRST   = 8'hC0;
  localparam logic [7:0] LEAD3_FIRST   = 8'hE0;
  localparam logic [7:0] LEAD4_FIRST   = 8'hF0;
  localparam logic [7:0] INVALID_FIRST = 8'hF5;

  localparam logic [4:0] LEAD2_MASK = 5'h1F;
  localparam logic [3:0] LEAD3_MASK = 4'h0F;
  localparam logic [2:0] LEAD4_MASK = 3'h07;
  localparam logic [5:0] CONT_MASK  = 6'h3F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } u8lc_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] line_number;
    logic [COUNT_W-1:0] column_number;
    logic               end_of_text;
  } u8lc_result_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_ONE;
  endfunction

  function automatic logic is_break(input logic [CP_W-1:0] cp);
    is_break = (cp == CP_LF) || (cp == CP_CR) || (cp == CP_LS) || (cp == CP_PS);
  endfunction

endpackage
`default_nettype wire

@@ hdl/u8lc_if.sv @@
// u8lc_in_if, u8lc_out_if: valid/ready channels for input bytes and positions
// depends on u8lc_pkg
`timescale 1ns / 1ps
`default_nettype none
interface u8lc_in_if import u8lc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8lc_out_if import u8lc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] line_number;
  logic [COUNT_W-1:0] column_number;
  logic               end_of_text;

  modport source (output valid, output line_number, output column_number,
                  output end_of_text, input ready);
  modport sink (input valid, input line_number, input column_number,
                input end_of_text, output ready);
endinterface
`default_nettype wire

@@ hdl/utf8_line_column_tracker.sv @@
// utf8_line_column_tracker: top level with input register and result register
// depends on u8lc_pkg, u8lc_in_if, u8lc_out_if and u8lc_step
// an item passes two register stages, the input register then the result register
// throughput: 1 item per cycle unless out_ch stalls; combinational count update
// a waiting result holds the input register; input stalls once both stages are full
// reset: synchronous active-low rst_n; line and column return to 1, channels empty
`timescale 1ns / 1ps
`default_nettype none
module utf8_line_column_tracker import u8lc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  u8lc_in_if.sink    in_ch,
  u8lc_out_if.source out_ch
);

  logic         s1_valid_r, s1_valid_nxt;
  u8lc_item_t   s1_item_r;
  logic         out_valid_r, out_valid_nxt;
  u8lc_result_t out_res_r;
  u8lc_result_t step_res;
  logic         s1_adv;
  logic         in_fire;

  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_fire = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || s1_adv;

  u8lc_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_adv),
    .item   (s1_item_r),
    .result (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.data_byte <= in_ch.data_byte;
      s1_item_r.last_byte <= in_ch.last_byte;
    end
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.line_number   = out_res_r.line_number;
  assign out_ch.column_number = out_res_r.column_number;
  assign out_ch.end_of_text   = out_res_r.end_of_text;

endmodule
`default_nettype wire

@@ hdl/u8lc_step.sv @@
// u8lc_step: tracker state and the per-item decode and count update
// depends on u8lc_pkg
`timescale 1ns / 1ps
`default_nettype none
module u8lc_step import u8lc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         fire,
  input  wire u8lc_item_t   item,
  output u8lc_result_t      result
);

  logic [COUNT_W-1:0] line_count_r, line_count_nxt;
  logic [COUNT_W-1:0] column_count_r, column_count_nxt;
  logic [1:0]         bytes_left_r, bytes_left_nxt;
  logic [CP_W-1:0]    partial_cp_r, partial_cp_nxt;
  logic               after_cr_r, after_cr_nxt;

  logic [7:0]         b;
  logic [1:0]         bl_dec;
  logic [CP_W-1:0]    cont_cp;
  logic               count_en;
  logic               plain_col;
  logic [CP_W-1:0]    count_cp;
  logic               brk;
  logic [COUNT_W-1:0] line_new;
  logic [COUNT_W-1:0] col_new;
  logic [1:0]         bl_new;
  logic [CP_W-1:0]    cp_new;
  logic               cr_new;

  assign b       = item.data_byte;
  assign bl_dec  = bytes_left_r - 2'd1;
  assign cont_cp = {partial_cp_r[CP_W-7:0], b[5:0] & CONT_MASK};

  always_comb begin
    count_en  = 1'b0;
    plain_col = 1'b0;
    count_cp  = cont_cp;
    bl_new    = bytes_left_r;
    cp_new    = partial_cp_r;
    cr_new    = 1'b0;
    if (bytes_left_r != 2'd0) begin
      bl_new = bl_dec;
      cp_new = cont_cp;
      if (bl_dec == 2'd0) begin
        count_en = 1'b1;
      end else if (item.last_byte) begin
        count_en  = 1'b1;
        plain_col = 1'b1;
      end
    end else if (item.last_byte) begin
      count_en = 1'b0;
    end else if (b == BYTE_LF && after_cr_r) begin
      cr_new = 1'b0;
    end else if (b < LEAD2_FIRST || b >= INVALID_FIRST) begin
      count_en = 1'b1;
      count_cp = {{(CP_W-8){1'b0}}, b};
      cr_new   = (b == BYTE_CR);
    end else if (b < LEAD3_FIRST) begin
      bl_new = 2'd1;
      cp_new = {{(CP_W-5){1'b0}}, b[4:0] & LEAD2_MASK};
    end else if (b < LEAD4_FIRST) begin
      bl_new = 2'd2;
      cp_new = {{(CP_W-4){1'b0}}, b[3:0] & LEAD3_MASK};
    end else begin
      bl_new = 2'd3;
      cp_new = {{(CP_W-3){1'b0}}, b[2:0] & LEAD4_MASK};
    end
  end

  assign brk      = count_en && !plain_col && is_break(count_cp);
  assign line_new = brk ? sat_inc(line_count_r) : line_count_r;
  assign col_new  = brk ? COUNT_ONE :
                    (count_en ? sat_inc(column_count_r) : column_count_r);

  assign result.line_number   = line_new;
  assign result.column_number = col_new;
  assign result.end_of_text   = item.last_byte;

  always_comb begin
    line_count_nxt   = line_count_r;
    column_count_nxt = column_count_r;
    bytes_left_nxt   = bytes_left_r;
    partial_cp_nxt   = partial_cp_r;
    after_cr_nxt     = after_cr_r;
    if (fire) begin
      if (item.last_byte) begin
        line_count_nxt   = COUNT_ONE;
        column_count_nxt = COUNT_ONE;
        bytes_left_nxt   = 2'd0;
        partial_cp_nxt   = '0;
        after_cr_nxt     = 1'b0;
      end else begin
        line_count_nxt   = line_new;
        column_count_nxt = col_new;
        bytes_left_nxt   = bl_new;
        partial_cp_nxt   = cp_new;
        after_cr_nxt     = cr_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r   <= COUNT_ONE;
      column_count_r <= COUNT_ONE;
      bytes_left_r   <= 2'd0;
      partial_cp_r   <= '0;
      after_cr_r     <= 1'b0;
    end else begin
      line_count_r   <= line_count_nxt;
      column_count_r <= column_count_nxt;
      bytes_left_r   <= bytes_left_nxt;
      partial_cp_r   <= partial_cp_nxt;
      after_cr_r     <= after_cr_nxt;
    end
  end

  a_counts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_count_r != '0 && column_count_r != '0)
    else $error("line or column count reached zero");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.last_byte |=> line_count_r == COUNT_ONE &&
      column_count_r == COUNT_ONE && bytes_left_r == 2'd0 && !after_cr_r)
    else $error("state not cleared after end of text");

  a_cr_outside_seq: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r != 2'd0 |-> !after_cr_r)
    else $error("cr flag set inside a multi-byte sequence");

  a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.last_byte |=> line_count_r >= $past(line_count_r))
    else $error("line count went backwards within a text");

endmodule
`default_nettype wire
